// ===== rtl/tdq_pkg.sv =====
// Package for the tail-drop queue with delay statistics.
// Holds field widths, reset values, register indexes and the state and status codes.
// No dependencies.
package tdq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_NUM_SOURCES = 16;
  localparam int DEF_TIME_BITS   = 32;

  localparam int CAP_W   = 7;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 48;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = 7'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef enum logic [2:0] {
    EV_SERVED      = 3'd0,
    EV_QUEUED      = 3'd1,
    EV_DROPPED     = 3'd2,
    EV_DEPART_NEXT = 3'd3,
    EV_DEPART_IDLE = 3'd4,
    EV_IGNORED     = 3'd5
  } status_t;

  typedef enum logic {
    REQ_ARRIVAL   = 1'b0,
    REQ_DEPARTURE = 1'b1
  } req_t;

endpackage

// ===== rtl/tdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the packet slots of the queue. No dependencies.
module tdq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tail_drop_queue_with_delay_stats.sv =====
// An input item is registered when accepted; the event is applied in the execute state once
// the output register is free, and its result is registered with m_tvalid.
// A new item is accepted only once the last one is applied; each event waits in the execute
// state for the registered read of the head slot of the packet memory before it is applied.
// Reset is synchronous: counters, sums, ring pointers and the server clear, and the
// capacity register returns to 50. The slot memory is not cleared.
module tail_drop_queue_with_delay_stats import tdq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NUM_SOURCES = DEF_NUM_SOURCES,
  parameter int TIME_BITS   = DEF_TIME_BITS,
  localparam int IDX_W  = $clog2(QUEUE_DEPTH),
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1,
  localparam int IN_W   = ((TIME_BITS + SRC_W + 7) / 8) * 8,
  localparam int OUT_RAW_W = 2 * CNT_W + SRC_W + 2 * TIME_BITS + 3 * COUNT_W + 2 * SUM_W,
  localparam int OUT_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // event_time, packet_source
  input  logic [IN_W-1:0]   s_tdata,
  // req_type
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // queue_count, served_source, end_to_end_delay, wait_delay, generated_total,
  // delivered_total, dropped_total, peak_queue, wait_delay_sum, end_to_end_sum
  output logic [OUT_W-1:0]  m_tdata,
  // event_status
  output logic [2:0]        m_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SLOT_W = TIME_BITS + SRC_W;
  localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SUMX_W = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [TIME_BITS-1:0] d);
    logic [SUMX_W-1:0] total;
    total = SUMX_W'(s) + SUMX_W'(d);
    return (total > SUMX_W'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  state_t state;
  logic [CAP_W-1:0] capacity;

  logic                 req;
  logic [TIME_BITS-1:0] ev_time;
  logic [SRC_W-1:0]     ev_src;
  logic [TIME_BITS-1:0] e2e_pre;

  logic [IDX_W-1:0]     head_index, tail_index;
  logic [CNT_W-1:0]     occupancy, peak_occupancy;
  logic                 in_service;
  logic [TIME_BITS-1:0] serving_arrival;
  logic [SRC_W-1:0]     serving_source;
  logic [COUNT_W-1:0]   arrivals_count, departures_count, drops_count;
  logic [SUM_W-1:0]     wait_sum, transit_sum;

  logic [IDX_W-1:0]     head_index_next, tail_index_next;
  logic [CNT_W-1:0]     occupancy_next, peak_occupancy_next;
  logic                 in_service_next;
  logic [TIME_BITS-1:0] serving_arrival_next;
  logic [SRC_W-1:0]     serving_source_next;
  logic [COUNT_W-1:0]   arrivals_count_next, departures_count_next, drops_count_next;
  logic [SUM_W-1:0]     wait_sum_next, transit_sum_next;
  status_t              status_next;
  logic [TIME_BITS-1:0] e2e_next, wait_next;
  logic                 slot_we;

  logic [SLOT_W-1:0]    slot_rdata;
  logic [TIME_BITS-1:0] head_time;
  logic [SRC_W-1:0]     head_src;
  logic [LIM_W-1:0]     limit;
  logic                 fire;
  logic                 cfg_write;

  status_t              out_status;
  logic [CNT_W-1:0]     out_count, out_peak;
  logic [SRC_W-1:0]     out_src;
  logic [TIME_BITS-1:0] out_e2e, out_wait;
  logic [COUNT_W-1:0]   out_gen, out_del, out_drop;
  logic [SUM_W-1:0]     out_wsum, out_esum;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity) : '0;

  assign s_tready = (state == ST_IDLE);
  assign fire     = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign limit = (LIM_W'(capacity) > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH)
                                                          : LIM_W'(capacity);
  assign head_time = slot_rdata[TIME_BITS-1:0];
  assign head_src  = slot_rdata[TIME_BITS +: SRC_W];

  tdq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (slot_we),
    .waddr(tail_index),
    .wdata({ev_src, ev_time}),
    .raddr(head_index),
    .rdata(slot_rdata)
  );

  always_comb begin
    head_index_next       = head_index;
    tail_index_next       = tail_index;
    occupancy_next        = occupancy;
    peak_occupancy_next   = peak_occupancy;
    in_service_next       = in_service;
    serving_arrival_next  = serving_arrival;
    serving_source_next   = serving_source;
    arrivals_count_next   = arrivals_count;
    departures_count_next = departures_count;
    drops_count_next      = drops_count;
    wait_sum_next         = wait_sum;
    transit_sum_next      = transit_sum;
    e2e_next              = '0;
    wait_next             = '0;
    slot_we               = 1'b0;
    status_next           = EV_IGNORED;
    if (req == REQ_ARRIVAL) begin
      arrivals_count_next = sat_inc(arrivals_count);
      if (!in_service) begin
        in_service_next      = 1'b1;
        serving_arrival_next = ev_time;
        serving_source_next  = ev_src;
        status_next          = EV_SERVED;
      end else if (LIM_W'(occupancy) < limit) begin
        slot_we         = fire;
        tail_index_next = ring_next(tail_index);
        occupancy_next  = occupancy + CNT_W'(1);
        if (occupancy_next > peak_occupancy) begin
          peak_occupancy_next = occupancy_next;
        end
        status_next = EV_QUEUED;
      end else begin
        drops_count_next = sat_inc(drops_count);
        status_next      = EV_DROPPED;
      end
    end else if (in_service) begin
      departures_count_next = sat_inc(departures_count);
      e2e_next              = e2e_pre;
      transit_sum_next      = sat_add(transit_sum, e2e_pre);
      if (occupancy != '0) begin
        serving_arrival_next = head_time;
        serving_source_next  = head_src;
        head_index_next      = ring_next(head_index);
        occupancy_next       = occupancy - CNT_W'(1);
        wait_next            = ev_time - head_time;
        wait_sum_next        = sat_add(wait_sum, wait_next);
        status_next          = EV_DEPART_NEXT;
      end else begin
        in_service_next      = 1'b0;
        serving_arrival_next = '0;
        serving_source_next  = '0;
        status_next          = EV_DEPART_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      capacity         <= CAP_RESET;
      m_tvalid         <= 1'b0;
      head_index       <= '0;
      tail_index       <= '0;
      occupancy        <= '0;
      peak_occupancy   <= '0;
      in_service       <= 1'b0;
      serving_arrival  <= '0;
      serving_source   <= '0;
      arrivals_count   <= '0;
      departures_count <= '0;
      drops_count      <= '0;
      wait_sum         <= '0;
      transit_sum      <= '0;
    end else begin
      if (cfg_write) begin
        capacity <= pwdata[CAP_W-1:0];
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state            <= ST_IDLE;
            head_index       <= head_index_next;
            tail_index       <= tail_index_next;
            occupancy        <= occupancy_next;
            peak_occupancy   <= peak_occupancy_next;
            in_service       <= in_service_next;
            serving_arrival  <= serving_arrival_next;
            serving_source   <= serving_source_next;
            arrivals_count   <= arrivals_count_next;
            departures_count <= departures_count_next;
            drops_count      <= drops_count_next;
            wait_sum         <= wait_sum_next;
            transit_sum      <= transit_sum_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req     <= s_tuser;
      ev_time <= s_tdata[TIME_BITS-1:0];
      ev_src  <= s_tdata[TIME_BITS +: SRC_W];
      e2e_pre <= s_tdata[TIME_BITS-1:0] - serving_arrival;
    end
    if (fire) begin
      out_status <= status_next;
      out_count  <= occupancy_next;
      out_src    <= in_service_next ? serving_source_next : '0;
      out_e2e    <= e2e_next;
      out_wait   <= wait_next;
      out_gen    <= arrivals_count_next;
      out_del    <= departures_count_next;
      out_drop   <= drops_count_next;
      out_peak   <= peak_occupancy_next;
      out_wsum   <= wait_sum_next;
      out_esum   <= transit_sum_next;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = OUT_W'({out_esum, out_wsum, out_peak, out_drop, out_del, out_gen,
                           out_wait, out_e2e, out_src, out_count});

endmodule
